// File: sv/tfn_pkg.sv
package tfn_pkg;

    localparam int unsigned CoordBits = 16;
    localparam int unsigned IndexBits = 16;
    localparam int unsigned NormBits  = 16;

    typedef struct packed {
        logic [IndexBits-1:0]        vert_a;
        logic [IndexBits-1:0]        vert_b;
        logic [IndexBits-1:0]        vert_c;
        logic signed [CoordBits-1:0] ax;
        logic signed [CoordBits-1:0] ay;
        logic signed [CoordBits-1:0] az;
        logic signed [CoordBits-1:0] bx;
        logic signed [CoordBits-1:0] by_coord;
        logic signed [CoordBits-1:0] bz;
        logic signed [CoordBits-1:0] cx;
        logic signed [CoordBits-1:0] cy;
        logic signed [CoordBits-1:0] cz;
    } t_tri_in;

    typedef struct packed {
        logic [IndexBits-1:0]       out_a;
        logic [IndexBits-1:0]       out_b;
        logic [IndexBits-1:0]       out_c;
        logic signed [NormBits-1:0] nx;
        logic signed [NormBits-1:0] ny;
        logic signed [NormBits-1:0] nz;
        logic                       degenerate;
    } t_tri_out;

endpackage

// File: sv/triangle_face_normal.sv
// Each accepted start gives one o_valid strobe with its result at the end of the pipeline.
// Throughput: one triangle per cycle; busy is always low, the pipeline never stalls.
// The depth is set by the 32-step square root and the 16-step restoring dividers.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_tri_in  i_tri,
    output logic     o_valid,
    output t_tri_out o_result
);

    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned DivSteps  = 16;
    localparam int unsigned Depth     = 5 + SqrtSteps + 1 + DivSteps + 1;

    // Index sidebands and valid bits delayed through the whole pipeline.
    logic [Depth-1:0]           r_vld;
    logic [3*IndexBits-1:0]     r_idx [Depth-1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Depth-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= {i_tri.vert_a, i_tri.vert_b, i_tri.vert_c};
        for (int s = 1; s < Depth - 1; s++) begin
            r_idx[s] <= r_idx[s-1];
        end
    end

    // Stage 1: edges.
    logic signed [CoordBits:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    always_ff @(posedge i_clk) begin
        r_e1x <= {i_tri.bx[CoordBits-1], i_tri.bx} - {i_tri.ax[CoordBits-1], i_tri.ax};
        r_e1y <= {i_tri.by_coord[CoordBits-1], i_tri.by_coord}
               - {i_tri.ay[CoordBits-1], i_tri.ay};
        r_e1z <= {i_tri.bz[CoordBits-1], i_tri.bz} - {i_tri.az[CoordBits-1], i_tri.az};
        r_e2x <= {i_tri.cx[CoordBits-1], i_tri.cx} - {i_tri.ax[CoordBits-1], i_tri.ax};
        r_e2y <= {i_tri.cy[CoordBits-1], i_tri.cy} - {i_tri.ay[CoordBits-1], i_tri.ay};
        r_e2z <= {i_tri.cz[CoordBits-1], i_tri.cz} - {i_tri.az[CoordBits-1], i_tri.az};
    end

    // Stage 2: six products.
    localparam int unsigned PW = 2*CoordBits + 2;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    always_ff @(posedge i_clk) begin
        r_p0 <= PW'(r_e1y * r_e2z);
        r_p1 <= PW'(r_e1z * r_e2y);
        r_p2 <= PW'(r_e1z * r_e2x);
        r_p3 <= PW'(r_e1x * r_e2z);
        r_p4 <= PW'(r_e1x * r_e2y);
        r_p5 <= PW'(r_e1y * r_e2x);
    end

    // Stage 3: cross product, split into sign and magnitude.
    localparam int unsigned MW = PW;
    logic [MW-1:0] r_ax, r_ay, r_az;
    logic [2:0]    r_sg3;
    logic signed [PW-1:0] w_cx, w_cy, w_cz;
    assign w_cx = r_p0 - r_p1;
    assign w_cy = r_p2 - r_p3;
    assign w_cz = r_p4 - r_p5;
    always_ff @(posedge i_clk) begin
        r_ax  <= w_cx[PW-1] ? MW'(-w_cx) : MW'(w_cx);
        r_ay  <= w_cy[PW-1] ? MW'(-w_cy) : MW'(w_cy);
        r_az  <= w_cz[PW-1] ? MW'(-w_cz) : MW'(w_cz);
        r_sg3 <= {w_cx[PW-1], w_cy[PW-1], w_cz[PW-1]};
    end

    // Stage 4: align so the largest magnitude has its top bit at bit 30.
    logic [MW-1:0] w_or;
    logic [5:0]    w_top;
    logic [30:0]   r_nx, r_ny, r_nz;
    logic [2:0]    r_sg4;
    logic          r_dg4;
    assign w_or = r_ax | r_ay | r_az;
    always_comb begin
        w_top = '0;
        for (int b = 0; b < MW; b++) begin
            if (w_or[b]) begin
                w_top = 6'(b);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_top > 6'd30) begin
            r_nx <= 31'(r_ax >> (w_top - 6'd30));
            r_ny <= 31'(r_ay >> (w_top - 6'd30));
            r_nz <= 31'(r_az >> (w_top - 6'd30));
        end else begin
            r_nx <= 31'(r_ax << (6'd30 - w_top));
            r_ny <= 31'(r_ay << (6'd30 - w_top));
            r_nz <= 31'(r_az << (6'd30 - w_top));
        end
        r_sg4 <= r_sg3;
        r_dg4 <= (w_or == '0);
    end

    // Stage 5: sum of squares (below 3 * 2^62, so 64 bits hold it).
    logic [63:0] r_sum;
    logic [30:0] r_qx, r_qy, r_qz;
    logic [2:0]  r_sg5;
    logic        r_dg5;
    always_ff @(posedge i_clk) begin
        r_sum <= 64'(r_nx * r_nx) + 64'(r_ny * r_ny) + 64'(r_nz * r_nz);
        r_qx  <= r_nx;
        r_qy  <= r_ny;
        r_qz  <= r_nz;
        r_sg5 <= r_sg4;
        r_dg5 <= r_dg4;
    end

    // Square root, one result bit per stage.
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
        logic [30:0] ax;
        logic [30:0] ay;
        logic [30:0] az;
        logic [2:0]  sg;
        logic        dg;
    } t_sq;
    t_sq r_sq [SqrtSteps+1];
    always_comb begin
        r_sq[0] = '{rem: r_sum, root: '0, ax: r_qx, ay: r_qy, az: r_qz, sg: r_sg5, dg: r_dg5};
    end
    for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
        localparam int unsigned Sh = 2*(SqrtSteps-1-g);
        logic [63:0] w_trial;
        t_sq         n_sq;
        // Trial is (2 * root + 2^b) * 2^b for result bit b.
        assign w_trial = ({32'd0, r_sq[g].root} << (SqrtSteps - g)) | (64'd1 << Sh);
        always_comb begin
            n_sq = r_sq[g];
            if (r_sq[g].rem >= w_trial) begin
                n_sq.rem  = r_sq[g].rem - w_trial;
                n_sq.root = r_sq[g].root | (32'd1 << (SqrtSteps-1-g));
            end
        end
        always_ff @(posedge i_clk) begin
            r_sq[g+1] <= n_sq;
        end
    end

    // Numerators a*16384 + r/2 (47 bits); quotients fit in 15 bits before clamping.
    typedef struct packed {
        logic [46:0] rx;
        logic [46:0] ry;
        logic [46:0] rz;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [31:0] dv;
        logic [2:0]  sg;
        logic        dg;
    } t_dv;
    t_dv r_dv [DivSteps+1];
    always_ff @(posedge i_clk) begin
        r_dv[0].rx <= 47'({r_sq[SqrtSteps].ax, 14'd0}) + 47'(r_sq[SqrtSteps].root >> 1);
        r_dv[0].ry <= 47'({r_sq[SqrtSteps].ay, 14'd0}) + 47'(r_sq[SqrtSteps].root >> 1);
        r_dv[0].rz <= 47'({r_sq[SqrtSteps].az, 14'd0}) + 47'(r_sq[SqrtSteps].root >> 1);
        r_dv[0].qx <= '0;
        r_dv[0].qy <= '0;
        r_dv[0].qz <= '0;
        r_dv[0].dv <= r_sq[SqrtSteps].root;
        r_dv[0].sg <= r_sq[SqrtSteps].sg;
        r_dv[0].dg <= r_sq[SqrtSteps].dg;
    end

    // Restoring division, one quotient bit per stage for all three components.
    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        localparam int unsigned Sh = DivSteps-1-g;
        logic [46:0] w_d;
        t_dv         n_dv;
        assign w_d = 47'(r_dv[g].dv) << Sh;
        always_comb begin
            n_dv = r_dv[g];
            if (r_dv[g].rx >= w_d) begin
                n_dv.rx     = r_dv[g].rx - w_d;
                n_dv.qx[Sh] = 1'b1;
            end
            if (r_dv[g].ry >= w_d) begin
                n_dv.ry     = r_dv[g].ry - w_d;
                n_dv.qy[Sh] = 1'b1;
            end
            if (r_dv[g].rz >= w_d) begin
                n_dv.rz     = r_dv[g].rz - w_d;
                n_dv.qz[Sh] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            r_dv[g+1] <= n_dv;
        end
    end

    // Final stage: clamp, apply sign, zero on a degenerate triangle.
    function automatic logic [15:0] fin(input logic [15:0] q, input logic s, input logic d);
        logic [15:0] c;
        c = (q > 16'd16384) ? 16'd16384 : q;
        if (d) begin
            return '0;
        end
        return s ? 16'(-c) : c;
    endfunction

    always_ff @(posedge i_clk) begin
        o_result.out_a      <= r_idx[Depth-2][3*IndexBits-1:2*IndexBits];
        o_result.out_b      <= r_idx[Depth-2][2*IndexBits-1:IndexBits];
        o_result.out_c      <= r_idx[Depth-2][IndexBits-1:0];
        o_result.nx         <= fin(r_dv[DivSteps].qx, r_dv[DivSteps].sg[2], r_dv[DivSteps].dg);
        o_result.ny         <= fin(r_dv[DivSteps].qy, r_dv[DivSteps].sg[1], r_dv[DivSteps].dg);
        o_result.nz         <= fin(r_dv[DivSteps].qz, r_dv[DivSteps].sg[0], r_dv[DivSteps].dg);
        o_result.degenerate <= r_dv[DivSteps].dg;
    end
    assign o_valid = r_vld[Depth-1];

    // On a valid result, the degenerate flag and a nonzero normal never appear together.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.degenerate |-> (o_result.nx == 0 && o_result.ny == 0
                                            && o_result.nz == 0))
        else $error("degenerate result with nonzero normal");

    // Each result strobe must come from a valid bit in the last stage before the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[Depth-2]))
        else $error("result strobe without a matching transfer");

    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

endmodule
